>>> design/mftr_pkg.sv
`timescale 1ns / 1ps

package mftr_pkg;

  localparam int MAX_SLOTS       = 64;
  localparam int SLOTS_PER_FRAME = 8;
  localparam int PAYLOAD_WIDTH   = 64;

  localparam int SLOT_W   = $clog2(MAX_SLOTS);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int MODE_W   = 2;
  localparam int FID_W    = 11;
  localparam int POS_W    = 3;
  localparam int DATA_W   = 64;
  localparam int TCNT_W   = 16;
  localparam int CYC_W    = 16;
  localparam int AGE_W    = 32;
  localparam int IDX_W    = FID_W + 6;
  localparam int NUM_REGS = 5;
  localparam int REG_W    = 32;
  localparam int RIDX_W   = $clog2(NUM_REGS);
  localparam int ADDR_W   = RIDX_W + 2;

  localparam logic [AGE_W-1:0] TIMEOUT_RST    = AGE_W'(100);
  localparam logic [FID_W-1:0] LAST_FRAME_RST = FID_W'(7);

  typedef enum logic [MODE_W-1:0] {
    MODE_HEADER  = 2'd0,
    MODE_ELEMENT = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [RIDX_W-1:0] {
    REG_PUBLISH_PARTIAL = 3'd0,
    REG_TIMEOUT_TICKS   = 3'd1,
    REG_MAX_TARGETS     = 3'd2,
    REG_FIRST_FRAME_ID  = 3'd3,
    REG_LAST_FRAME_ID   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_LOAD,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic             partial_en;
    logic [AGE_W-1:0] timeout_ticks;
    logic [CNT_W-1:0] target_cap;
    logic [FID_W-1:0] first_frame_no;
    logic [FID_W-1:0] last_frame_no;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [FID_W-1:0]  frame_no;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] target_data;
    logic [TCNT_W-1:0] target_count;
    logic [CYC_W-1:0]  cycle_number;
  } item_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } ram_req_t;

endpackage

>>> design/mftr_in_if.sv
`timescale 1ns / 1ps

interface mftr_in_if;
  logic                        valid;
  logic                        ready;
  logic [mftr_pkg::MODE_W-1:0] mode;
  logic [mftr_pkg::FID_W-1:0]  frame_no;
  logic [mftr_pkg::POS_W-1:0]  position;
  logic [mftr_pkg::DATA_W-1:0] target_data;
  logic [mftr_pkg::TCNT_W-1:0] target_count;
  logic [mftr_pkg::CYC_W-1:0]  cycle_number;

  modport source (
    output valid, mode, frame_no, position, target_data, target_count, cycle_number,
    input  ready
  );
  modport sink (
    input  valid, mode, frame_no, position, target_data, target_count, cycle_number,
    output ready
  );
endinterface

>>> design/mftr_out_if.sv
`timescale 1ns / 1ps

interface mftr_out_if;
  logic                        valid;
  logic                        ready;
  logic [mftr_pkg::CYC_W-1:0]  out_cycle_number;
  logic [mftr_pkg::SLOT_W-1:0] slot_index;
  logic [mftr_pkg::DATA_W-1:0] out_target_data;
  logic                        is_partial;
  logic                        is_empty;
  logic                        last;

  modport source (
    output valid, out_cycle_number, slot_index, out_target_data, is_partial, is_empty,
           last,
    input  ready
  );
  modport sink (
    input  valid, out_cycle_number, slot_index, out_target_data, is_partial, is_empty,
           last,
    output ready
  );
endinterface

>>> design/multi_frame_target_list_reassembler_core.sv
`timescale 1ns / 1ps

// channel   dir  handshake       payload
// in_i      in   valid / ready   mode, frame_no, position, target_data, target_count,
//                                cycle_number
// out_o     out  valid / ready   out_cycle_number, slot_index, out_target_data,
//                                is_partial, is_empty, last
// apb       in   psel / penable  paddr, pwdata -> prdata (pready tied high)
//
// Every item is accepted, then run through the shared index unit in an execute step.
// A completed cycle drains through the two-port slot memory: the scan finds each filled
// slot, which is read, loaded, then sent and held until taken; an empty header gives
// one item. in_i.ready stays low until the last item of a drain is taken.
// Reset clears all control state at once; no clearing pass.

module multi_frame_target_list_reassembler_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mftr_in_if.sink                     in_i,
  mftr_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mftr_pkg::ADDR_W-1:0] paddr,
  input  logic [mftr_pkg::REG_W-1:0]  pwdata,
  output logic [mftr_pkg::REG_W-1:0]  prdata,
  output logic                        pready
);

  mftr_pkg::cfg_t                     cfg;
  mftr_pkg::ram_req_t                 ram_req;
  logic [mftr_pkg::PAYLOAD_WIDTH-1:0] ram_wdata;
  logic [mftr_pkg::PAYLOAD_WIDTH-1:0] ram_rdata;

  mftr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mftr_slot_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .wr_data_i (ram_wdata),
    .rd_data_o (ram_rdata)
  );

  mftr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_req_o   (ram_req),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

endmodule

>>> design/mftr_cfg_regs.sv
`timescale 1ns / 1ps

module mftr_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mftr_pkg::ADDR_W-1:0] paddr,
  input  logic [mftr_pkg::REG_W-1:0]  pwdata,
  output logic [mftr_pkg::REG_W-1:0]  prdata,
  output logic                        pready,
  output mftr_pkg::cfg_t              cfg_o
);

  mftr_pkg::cfg_t                cfg_q, cfg_d;
  logic                          wr_en;
  logic [mftr_pkg::RIDX_W-1:0]   ridx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign ridx   = paddr[mftr_pkg::ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (ridx)
        mftr_pkg::REG_PUBLISH_PARTIAL: cfg_d.partial_en     = pwdata[0];
        mftr_pkg::REG_TIMEOUT_TICKS:   cfg_d.timeout_ticks  = pwdata[mftr_pkg::AGE_W-1:0];
        mftr_pkg::REG_MAX_TARGETS:     cfg_d.target_cap     = pwdata[mftr_pkg::CNT_W-1:0];
        mftr_pkg::REG_FIRST_FRAME_ID:  cfg_d.first_frame_no = pwdata[mftr_pkg::FID_W-1:0];
        mftr_pkg::REG_LAST_FRAME_ID:   cfg_d.last_frame_no  = pwdata[mftr_pkg::FID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      mftr_pkg::REG_PUBLISH_PARTIAL: prdata = mftr_pkg::REG_W'(cfg_q.partial_en);
      mftr_pkg::REG_TIMEOUT_TICKS:   prdata = mftr_pkg::REG_W'(cfg_q.timeout_ticks);
      mftr_pkg::REG_MAX_TARGETS:     prdata = mftr_pkg::REG_W'(cfg_q.target_cap);
      mftr_pkg::REG_FIRST_FRAME_ID:  prdata = mftr_pkg::REG_W'(cfg_q.first_frame_no);
      mftr_pkg::REG_LAST_FRAME_ID:   prdata = mftr_pkg::REG_W'(cfg_q.last_frame_no);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.partial_en     <= 1'b0;
      cfg_q.timeout_ticks  <= mftr_pkg::TIMEOUT_RST;
      cfg_q.target_cap     <= '0;
      cfg_q.first_frame_no <= '0;
      cfg_q.last_frame_no  <= mftr_pkg::LAST_FRAME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> design/mftr_slot_ram.sv
`timescale 1ns / 1ps

module mftr_slot_ram (
  input  logic                               clk_i,
  input  mftr_pkg::ram_req_t                 req_i,
  input  logic [mftr_pkg::PAYLOAD_WIDTH-1:0] wr_data_i,
  output logic [mftr_pkg::PAYLOAD_WIDTH-1:0] rd_data_o
);

  logic [mftr_pkg::PAYLOAD_WIDTH-1:0] mem [mftr_pkg::MAX_SLOTS];
  logic [mftr_pkg::PAYLOAD_WIDTH-1:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

endmodule

>>> design/mftr_ctrl.sv
`timescale 1ns / 1ps

module mftr_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mftr_pkg::cfg_t                     cfg_i,
  mftr_in_if.sink                            in_i,
  mftr_out_if.source                         out_o,
  output mftr_pkg::ram_req_t                 ram_req_o,
  output logic [mftr_pkg::PAYLOAD_WIDTH-1:0] ram_wdata_o,
  input  logic [mftr_pkg::PAYLOAD_WIDTH-1:0] ram_rdata_i
);

  localparam int SLOT_W = mftr_pkg::SLOT_W;
  localparam int CNT_W  = mftr_pkg::CNT_W;
  localparam int IDX_W  = mftr_pkg::IDX_W;
  localparam int TCNT_W = mftr_pkg::TCNT_W;
  localparam int AGE_W  = mftr_pkg::AGE_W;
  localparam int NSLOT  = mftr_pkg::MAX_SLOTS;

  mftr_pkg::state_e               state_q, state_d;
  mftr_pkg::item_t                item_q, item_d;
  logic                           open_q, open_d;
  logic [NSLOT-1:0]               filled_q, filled_d;
  logic [CNT_W-1:0]               fcnt_q, fcnt_d;
  logic [CNT_W-1:0]               exp_q, exp_d;
  logic [mftr_pkg::CYC_W-1:0]     held_q, held_d;
  logic [AGE_W-1:0]               age_q, age_d;
  logic [SLOT_W-1:0]              scan_q, scan_d;
  logic [CNT_W-1:0]               ecnt_q, ecnt_d;
  logic [SLOT_W-1:0]              oslot_q, oslot_d;
  logic [mftr_pkg::DATA_W-1:0]    odata_q, odata_d;
  logic                           opart_q, opart_d;
  logic                           oempty_q, oempty_d;
  logic                           olast_q, olast_d;

  logic                           in_acc;
  logic                           out_acc;
  logic [TCNT_W-1:0]              cnt_cap;
  logic [TCNT_W-1:0]              cnt_sat;
  logic [CNT_W-1:0]               hdr_cnt;
  logic [mftr_pkg::FID_W-1:0]     rel_fid;
  logic [IDX_W-1:0]               idx_w;
  logic                           elem_ok;
  logic [SLOT_W-1:0]              elem_slot;
  logic                           elem_store;
  logic [CNT_W-1:0]               fcnt_new;
  logic [AGE_W-1:0]               age_inc;
  logic                           emit_hdr;
  logic                           emit_elem;
  logic                           emit_tick;

  assign in_acc  = in_i.valid & in_i.ready;
  assign out_acc = out_o.valid & out_o.ready;

  // shared index, count and age unit working on the held item
  always_comb begin
    cnt_cap = item_q.target_count;
    if ((cfg_i.target_cap != '0) && (item_q.target_count > TCNT_W'(cfg_i.target_cap))) begin
      cnt_cap = TCNT_W'(cfg_i.target_cap);
    end
    cnt_sat = (cnt_cap > TCNT_W'(NSLOT)) ? TCNT_W'(NSLOT) : cnt_cap;
    hdr_cnt = cnt_sat[CNT_W-1:0];

    rel_fid   = item_q.frame_no - cfg_i.first_frame_no;
    idx_w     = IDX_W'(rel_fid) * IDX_W'(mftr_pkg::SLOTS_PER_FRAME) + IDX_W'(item_q.position);
    elem_slot = idx_w[SLOT_W-1:0];
    elem_ok   = open_q
              && (item_q.frame_no >= cfg_i.first_frame_no)
              && (item_q.frame_no <= cfg_i.last_frame_no)
              && (32'(item_q.position) < 32'(mftr_pkg::SLOTS_PER_FRAME))
              && (idx_w < IDX_W'(exp_q));
    elem_store = elem_ok && !filled_q[elem_slot];
    fcnt_new   = elem_store ? CNT_W'(fcnt_q + CNT_W'(1)) : fcnt_q;

    age_inc = (age_q == '1) ? age_q : AGE_W'(age_q + AGE_W'(1));

    emit_hdr  = (hdr_cnt == '0);
    emit_elem = elem_ok && (fcnt_new >= exp_q);
    emit_tick = open_q && cfg_i.partial_en && (fcnt_q != '0)
              && (age_inc >= cfg_i.timeout_ticks);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mftr_pkg::ST_IDLE: begin
        if (in_acc) state_d = mftr_pkg::ST_EXEC;
      end
      mftr_pkg::ST_EXEC: begin
        state_d = mftr_pkg::ST_IDLE;
        unique case (item_q.mode)
          mftr_pkg::MODE_HEADER:  if (emit_hdr)  state_d = mftr_pkg::ST_SEND;
          mftr_pkg::MODE_ELEMENT: if (emit_elem) state_d = mftr_pkg::ST_SCAN;
          mftr_pkg::MODE_TICK:    if (emit_tick) state_d = mftr_pkg::ST_SCAN;
          default: ;
        endcase
      end
      mftr_pkg::ST_SCAN: begin
        if (filled_q[scan_q]) state_d = mftr_pkg::ST_LOAD;
      end
      mftr_pkg::ST_LOAD: state_d = mftr_pkg::ST_SEND;
      mftr_pkg::ST_SEND: begin
        if (out_acc) state_d = olast_q ? mftr_pkg::ST_IDLE : mftr_pkg::ST_SCAN;
      end
      default: state_d = mftr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_d    = item_q;
    open_d    = open_q;
    filled_d  = filled_q;
    fcnt_d    = fcnt_q;
    exp_d     = exp_q;
    held_d    = held_q;
    age_d     = age_q;
    scan_d    = scan_q;
    ecnt_d    = ecnt_q;
    oslot_d   = oslot_q;
    odata_d   = odata_q;
    opart_d   = opart_q;
    oempty_d  = oempty_q;
    olast_d   = olast_q;
    ram_req_o = '0;
    ram_wdata_o = item_q.target_data[mftr_pkg::PAYLOAD_WIDTH-1:0];

    unique case (state_q)
      mftr_pkg::ST_IDLE: begin
        if (in_acc) begin
          item_d.mode         = in_i.mode;
          item_d.frame_no     = in_i.frame_no;
          item_d.position     = in_i.position;
          item_d.target_data  = in_i.target_data;
          item_d.target_count = in_i.target_count;
          item_d.cycle_number = in_i.cycle_number;
        end
      end
      mftr_pkg::ST_EXEC: begin
        scan_d = '0;
        ecnt_d = '0;
        unique case (item_q.mode)
          mftr_pkg::MODE_HEADER: begin
            open_d   = 1'b1;
            filled_d = '0;
            fcnt_d   = '0;
            age_d    = '0;
            exp_d    = hdr_cnt;
            held_d   = item_q.cycle_number;
            oslot_d  = '0;
            odata_d  = '0;
            opart_d  = 1'b0;
            oempty_d = 1'b1;
            olast_d  = 1'b1;
          end
          mftr_pkg::MODE_ELEMENT: begin
            if (elem_store) begin
              ram_req_o.wr_en     = 1'b1;
              ram_req_o.wr_addr   = elem_slot;
              filled_d[elem_slot] = 1'b1;
              fcnt_d              = fcnt_new;
            end
          end
          mftr_pkg::MODE_TICK: begin
            if (open_q) age_d = age_inc;
          end
          default: ;
        endcase
      end
      mftr_pkg::ST_SCAN: begin
        if (filled_q[scan_q]) begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = scan_q;
        end else begin
          scan_d = SLOT_W'(scan_q + SLOT_W'(1));
        end
      end
      mftr_pkg::ST_LOAD: begin
        oslot_d  = scan_q;
        odata_d  = mftr_pkg::DATA_W'(ram_rdata_i);
        opart_d  = (fcnt_q < exp_q);
        oempty_d = 1'b0;
        olast_d  = (CNT_W'(ecnt_q + CNT_W'(1)) == fcnt_q);
      end
      mftr_pkg::ST_SEND: begin
        if (out_acc) begin
          if (olast_q) begin
            open_d   = 1'b0;
            filled_d = '0;
            fcnt_d   = '0;
            exp_d    = '0;
            held_d   = '0;
            age_d    = '0;
          end else begin
            ecnt_d = CNT_W'(ecnt_q + CNT_W'(1));
            scan_d = SLOT_W'(scan_q + SLOT_W'(1));
          end
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready             = (state_q == mftr_pkg::ST_IDLE);
  assign out_o.valid            = (state_q == mftr_pkg::ST_SEND);
  assign out_o.out_cycle_number = held_q;
  assign out_o.slot_index       = oslot_q;
  assign out_o.out_target_data  = odata_q;
  assign out_o.is_partial       = opart_q;
  assign out_o.is_empty         = oempty_q;
  assign out_o.last             = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mftr_pkg::ST_IDLE;
      open_q   <= 1'b0;
      filled_q <= '0;
      fcnt_q   <= '0;
      exp_q    <= '0;
      held_q   <= '0;
      age_q    <= '0;
      scan_q   <= '0;
      ecnt_q   <= '0;
      opart_q  <= 1'b0;
      oempty_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      open_q   <= open_d;
      filled_q <= filled_d;
      fcnt_q   <= fcnt_d;
      exp_q    <= exp_d;
      held_q   <= held_d;
      age_q    <= age_d;
      scan_q   <= scan_d;
      ecnt_q   <= ecnt_d;
      opart_q  <= opart_d;
      oempty_q <= oempty_d;
      olast_q  <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    oslot_q <= oslot_d;
    odata_q <= odata_d;
  end

endmodule

>>> design/mftr_checker.sv
`timescale 1ns / 1ps

module mftr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mftr_pkg::SLOT_W-1:0] slot_index,
  input logic [mftr_pkg::DATA_W-1:0] out_target_data,
  input logic                        is_partial,
  input logic                        is_empty,
  input logic                        last
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_item_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted in back-to-back cycles");

  a_no_accept_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input ready while results pending");

  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && is_empty |-> last && !is_partial && (slot_index == '0)
                              && (out_target_data == '0))
    else $error("malformed empty marker");

endmodule

bind multi_frame_target_list_reassembler_core mftr_checker u_mftr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_i.valid),
  .in_ready        (in_i.ready),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .slot_index      (out_o.slot_index),
  .out_target_data (out_o.out_target_data),
  .is_partial      (out_o.is_partial),
  .is_empty        (out_o.is_empty),
  .last            (out_o.last)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mftr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_ITEMS   = 240;
  localparam int PHASE_ITEMS    = 48;

  typedef struct {
    logic [CYC_W-1:0]  cyc;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] data;
    logic              partial;
    logic              empty;
    logic              last_item;
  } target_rec_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [REG_W-1:0]   pwdata;
  logic [REG_W-1:0]   prdata;
  logic               pready;

  mftr_in_if  in_if ();
  mftr_out_if out_if ();

  multi_frame_target_list_reassembler_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // reassembly state as the block should hold it
  cfg_t              cfg;
  logic [DATA_W-1:0] slot_copy [MAX_SLOTS];
  bit                slot_seen [MAX_SLOTS];
  int                seen_cnt;
  int                want_cnt;
  bit                cyc_open;
  logic [CYC_W-1:0]  open_cyc_no;
  logic [AGE_W-1:0]  tick_age;

  target_rec_t targets_q [$];
  int          mismatch_cnt;
  int          sent_items;
  int          quiet_cycles;
  int          holdoff_reqs;
  bit          src_idle_en;
  bit          sink_stall_en;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void drop_open_cycle();
    int i;
    for (i = 0; i < MAX_SLOTS; i++) slot_seen[i] = 1'b0;
    seen_cnt    = 0;
    want_cnt    = 0;
    cyc_open    = 1'b0;
    open_cyc_no = '0;
    tick_age    = '0;
  endfunction

  function automatic void publish_cycle();
    target_rec_t rec;
    int          top;
    int          i;
    top = -1;
    for (i = 0; i < want_cnt; i++) if (slot_seen[i]) top = i;
    if (want_cnt == 0) begin
      rec = '{cyc: open_cyc_no, slot: '0, data: '0, partial: 1'b0, empty: 1'b1,
              last_item: 1'b1};
      targets_q = {targets_q, rec};
    end
    for (i = 0; i <= top; i++) begin
      if (slot_seen[i]) begin
        rec.cyc       = open_cyc_no;
        rec.slot      = SLOT_W'(i);
        rec.data      = slot_copy[i];
        rec.partial   = (seen_cnt < want_cnt);
        rec.empty     = 1'b0;
        rec.last_item = (i == top);
        targets_q = {targets_q, rec};
      end
    end
    drop_open_cycle();
  endfunction

  // advance the reassembly state by one accepted item
  function automatic void predict_reassembly(input item_t it);
    int slot;
    int cnt;
    case (it.mode)
      MODE_HEADER: begin
        drop_open_cycle();
        cnt = int'(it.target_count);
        if (cfg.target_cap != '0 && cnt > int'(cfg.target_cap)) cnt = int'(cfg.target_cap);
        if (cnt > MAX_SLOTS) cnt = MAX_SLOTS;
        cyc_open    = 1'b1;
        open_cyc_no = it.cycle_number;
        want_cnt    = cnt;
        if (cnt == 0) publish_cycle();
      end
      MODE_ELEMENT: begin
        if (cyc_open && it.frame_no >= cfg.first_frame_no &&
            it.frame_no <= cfg.last_frame_no) begin
          slot = (int'(it.frame_no) - int'(cfg.first_frame_no)) * SLOTS_PER_FRAME +
                 int'(it.position);
          if (slot < want_cnt && !slot_seen[slot]) begin
            slot_copy[slot] = it.target_data;
            slot_seen[slot] = 1'b1;
            seen_cnt++;
            if (seen_cnt >= want_cnt) publish_cycle();
          end
        end
      end
      MODE_TICK: begin
        if (cyc_open) begin
          if (tick_age != '1) tick_age++;
          if (cfg.partial_en && seen_cnt > 0 && tick_age >= cfg.timeout_ticks)
            publish_cycle();
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    target_rec_t exp_rec;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (targets_q.size() == 0) begin
        $error("unexpected item: cycle %0h slot %0d", out_if.out_cycle_number,
               out_if.slot_index);
        mismatch_cnt++;
      end else begin
        exp_rec = targets_q.pop_front();
        check_field("out_cycle_number", DATA_W'(exp_rec.cyc),
                    DATA_W'(out_if.out_cycle_number));
        check_field("slot_index", DATA_W'(exp_rec.slot), DATA_W'(out_if.slot_index));
        check_field("out_target_data", exp_rec.data, out_if.out_target_data);
        check_field("is_partial", DATA_W'(exp_rec.partial), DATA_W'(out_if.is_partial));
        check_field("is_empty", DATA_W'(exp_rec.empty), DATA_W'(out_if.is_empty));
        check_field("last", DATA_W'(exp_rec.last_item), DATA_W'(out_if.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : sink_ready
    int hold_left;
    int holdoff_done;
    hold_left     = 0;
    holdoff_done  = 0;
    out_if.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_reqs != holdoff_done) begin
        holdoff_done = holdoff_reqs;
        hold_left    = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = !(sink_stall_en && $urandom_range(0, 99) < 12);
      end
    end
  end

  task automatic send_item(input mode_e m, input logic [FID_W-1:0] fid,
                           input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] data,
                           input logic [TCNT_W-1:0] cnt, input logic [CYC_W-1:0] cyc);
    item_t it;
    it = '{mode: m, frame_no: fid, position: pos, target_data: data, target_count: cnt,
           cycle_number: cyc};
    @(negedge clk_i);
    while (src_idle_en && $urandom_range(0, 99) < 12) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.mode         = it.mode;
    in_if.frame_no     = it.frame_no;
    in_if.position     = it.position;
    in_if.target_data  = it.target_data;
    in_if.target_count = it.target_count;
    in_if.cycle_number = it.cycle_number;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_reassembly(it);
    sent_items++;
  endtask

  function automatic logic [DATA_W-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  task automatic send_header(input logic [TCNT_W-1:0] cnt, input logic [CYC_W-1:0] cyc);
    send_item(MODE_HEADER, FID_W'($urandom), POS_W'($urandom), rand_data(), cnt, cyc);
  endtask

  task automatic send_element(input logic [FID_W-1:0] fid, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] data);
    send_item(MODE_ELEMENT, fid, pos, data, TCNT_W'($urandom), CYC_W'($urandom));
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, FID_W'($urandom), POS_W'($urandom), rand_data(),
              TCNT_W'($urandom), CYC_W'($urandom));
  endtask

  task automatic send_noise();
    mode_e m;
    m = ($urandom_range(0, 7) == 0) ? MODE_HEADER : mode_e'($urandom_range(1, 3));
    send_item(m, FID_W'($urandom), POS_W'($urandom), rand_data(), TCNT_W'($urandom),
              CYC_W'($urandom));
  endtask

  task automatic send_slot(input int slot);
    send_element(FID_W'(int'(cfg.first_frame_no) + slot / SLOTS_PER_FRAME),
                 POS_W'(slot % SLOTS_PER_FRAME), rand_data());
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [REG_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(int'(idx) * 4);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_PUBLISH_PARTIAL: cfg.partial_en     = value[0];
      REG_TIMEOUT_TICKS:   cfg.timeout_ticks  = value[AGE_W-1:0];
      REG_MAX_TARGETS:     cfg.target_cap     = value[CNT_W-1:0];
      REG_FIRST_FRAME_ID:  cfg.first_frame_no = value[FID_W-1:0];
      REG_LAST_FRAME_ID:   cfg.last_frame_no  = value[FID_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (targets_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // close any open cycle with an empty header, then drain
  task automatic settle_block();
    if (cyc_open) send_header('0, '0);
    wait_drained();
  endtask

  task automatic test_default_config();
    send_header(16'd0, 16'hFFFF);
    send_element(11'd0, 3'd0, rand_data());
    send_tick();
    send_item(MODE_NONE, 11'd0, 3'd0, rand_data(), 16'd4, 16'h1111);
    send_header(16'd2, 16'h0001);
    send_element(11'd0, 3'd7, rand_data());
    send_element(11'd2047, 3'd1, rand_data());
    send_element(11'd0, 3'd1, '1);
    send_element(11'd0, 3'd1, '0);
    send_header(16'd3, 16'h0002);
    send_element(11'd0, 3'd2, '0);
    send_element(11'd0, 3'd0, 64'hA5A5_5A5A_F0F0_0F0F);
    send_element(11'd0, 3'd1, '1);
    send_header(16'hFFFF, 16'h0003);
    send_element(11'd7, 3'd7, rand_data());
    send_tick();
  endtask

  task automatic test_partial_publish();
    settle_block();
    write_reg(REG_PUBLISH_PARTIAL, 32'd1);
    write_reg(REG_TIMEOUT_TICKS, 32'd0);
    send_header(16'd20, 16'h0004);
    send_tick();
    send_element(11'd2, 3'd1, rand_data());
    send_element(11'd0, 3'd2, rand_data());
    send_tick();
    settle_block();
    write_reg(REG_TIMEOUT_TICKS, 32'd2);
    send_header(16'd10, 16'h0005);
    send_element(11'd0, 3'd3, rand_data());
    send_tick();
    send_tick();
  endtask

  task automatic test_frame_window();
    settle_block();
    write_reg(REG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
    write_reg(REG_MAX_TARGETS, 32'd1);
    write_reg(REG_FIRST_FRAME_ID, 32'd2047);
    write_reg(REG_LAST_FRAME_ID, 32'd2047);
    send_header(16'd100, 16'h8001);
    send_element(11'd2046, 3'd0, rand_data());
    send_tick();
    send_element(11'd2047, 3'd0, rand_data());
    settle_block();
    write_reg(REG_MAX_TARGETS, 32'd64);
    send_header(16'hFFFF, 16'h8002);
    send_element(11'd2047, 3'd7, rand_data());
    send_tick();
  endtask

  task automatic test_output_holdoff();
    int n;
    int p;
    settle_block();
    write_reg(REG_MAX_TARGETS, 32'd0);
    write_reg(REG_FIRST_FRAME_ID, 32'd0);
    write_reg(REG_LAST_FRAME_ID, 32'd7);
    @(posedge clk_i);
    holdoff_reqs++;
    src_idle_en = 1'b0;
    for (n = 0; n < 3; n++) begin
      send_header(16'd8, CYC_W'($urandom));
      for (p = 0; p < SLOTS_PER_FRAME; p++) send_element(11'd0, POS_W'(p), rand_data());
    end
    src_idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic load_phase_config(input int phase);
    logic [FID_W-1:0] lo;
    logic [FID_W-1:0] hi;
    int               pick;
    case (phase)
      0: begin
        write_reg(REG_PUBLISH_PARTIAL, 32'd1);
        write_reg(REG_TIMEOUT_TICKS, 32'd0);
        write_reg(REG_MAX_TARGETS, 32'd64);
        write_reg(REG_FIRST_FRAME_ID, 32'd0);
        write_reg(REG_LAST_FRAME_ID, 32'd2047);
      end
      1: begin
        write_reg(REG_PUBLISH_PARTIAL, 32'd0);
        write_reg(REG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
        write_reg(REG_MAX_TARGETS, 32'd1);
        write_reg(REG_FIRST_FRAME_ID, 32'd2047);
        write_reg(REG_LAST_FRAME_ID, 32'd2047);
      end
      default: begin
        write_reg(REG_PUBLISH_PARTIAL, 32'($urandom_range(0, 1)));
        pick = $urandom_range(0, 3);
        write_reg(REG_TIMEOUT_TICKS, (pick == 0) ? 32'd0 :
                                     (pick == 1) ? 32'($urandom_range(1, 6)) :
                                     (pick == 2) ? 32'd100 : 32'($urandom));
        write_reg(REG_MAX_TARGETS, $urandom_range(0, 1) ? 32'd0 :
                                   32'($urandom_range(1, 64)));
        lo = ($urandom_range(0, 3) == 0) ? '0 : FID_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) hi = '1;
        else if (pick == 1 && lo != '0) hi = lo - 1'b1;
        else hi = (int'(lo) + 7 > 2047) ? '1 : FID_W'(int'(lo) + $urandom_range(0, 7));
        write_reg(REG_FIRST_FRAME_ID, 32'(lo));
        write_reg(REG_LAST_FRAME_ID, 32'(hi));
      end
    endcase
  endtask

  task automatic run_target_cycle();
    int order [$];
    int pick;
    int cnt;
    int s;
    int j;
    int k;
    int tmp;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 5) cnt = 0;
    else if (pick < 75) cnt = $urandom_range(1, 12);
    else if (pick < 92) cnt = $urandom_range(13, 64);
    else cnt = $urandom_range(65, 65535);
    send_header(TCNT_W'(cnt), CYC_W'($urandom));
    for (s = 0; s < want_cnt; s++)
      if (int'(cfg.first_frame_no) + s / SLOTS_PER_FRAME <= int'(cfg.last_frame_no))
        order = {order, s};
    for (j = order.size() - 1; j > 0; j--) begin
      k        = $urandom_range(0, j);
      tmp      = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    n = order.size();
    if ($urandom_range(0, 99) < 15) n = $urandom_range(0, n);
    for (j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) send_tick();
      else if (pick < 14) send_noise();
      else if (pick < 18 && j > 0) send_slot(order[$urandom_range(0, j - 1)]);
      send_slot(order[j]);
    end
    k = 0;
    while (cyc_open && k < 12 && $urandom_range(0, 1) == 1) begin
      send_tick();
      k++;
    end
  endtask

  task automatic test_random_traffic();
    int base;
    int phase;
    base  = sent_items;
    phase = 0;
    while (sent_items - base < RANDOM_ITEMS) begin
      if (sent_items - base >= phase * PHASE_ITEMS) begin
        settle_block();
        load_phase_config(phase);
        src_idle_en   = (phase != 3);
        sink_stall_en = (phase != 3);
        phase++;
      end
      run_target_cycle();
    end
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.mode         = MODE_HEADER;
    in_if.frame_no     = '0;
    in_if.position     = '0;
    in_if.target_data  = '0;
    in_if.target_count = '0;
    in_if.cycle_number = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    mismatch_cnt       = 0;
    sent_items         = 0;
    quiet_cycles       = 0;
    holdoff_reqs       = 0;
    src_idle_en        = 1'b1;
    sink_stall_en      = 1'b1;
    cfg = '{partial_en: 1'b0, timeout_ticks: TIMEOUT_RST, target_cap: '0,
            first_frame_no: '0, last_frame_no: LAST_FRAME_RST};
    drop_open_cycle();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_config();
    test_partial_publish();
    test_frame_window();
    test_output_holdoff();
    test_random_traffic();

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0 && targets_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
